// File: hdl/scao_pkg.sv
`default_nettype none
package scao_pkg;

	localparam int MAX_IMAGE_SIDE = 64;
	localparam int MAX_MAGNIFY = 8;
	localparam int FRAME_SIDE = 4096;

	localparam int STORE_DEPTH = 4096;
	localparam int STORE_AW = 12;
	localparam int COORD_W = 12;
	localparam int ORIGIN_W = 13;
	localparam int DELTA_W = 14;
	localparam int IMAGE_W = 7;
	localparam int SCALE_W = 4;
	localparam int SPAN_W = 11;
	localparam int ADDR_SUM_W = 14;
	localparam int SUM_W = 16;
	localparam int PADDR_W = 5;

	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W = 19;

	localparam logic [7:0] FULL_ALPHA = 8'hff;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic [1:0] ORDER_RGB = 2'd0;
	localparam logic [1:0] ORDER_BGR = 2'd1;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_MAGNIFY = 3'd2;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
	localparam logic [2:0] REG_COLOR_ORDER = 3'd5;

	// Rounded-up reciprocals of the scale, so that (n * r) >> RECIP_SHIFT is n / scale.
	localparam logic [RECIP_W-1:0] RECIP_LUT [16] = '{
		RECIP_W'(0),
		RECIP_W'(((1 << RECIP_SHIFT) + 0) / 1),
		RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2),
		RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3),
		RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4),
		RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5),
		RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6),
		RECIP_W'(((1 << RECIP_SHIFT) + 6) / 7),
		RECIP_W'(((1 << RECIP_SHIFT) + 7) / 8),
		RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9),
		RECIP_W'(((1 << RECIP_SHIFT) + 9) / 10),
		RECIP_W'(((1 << RECIP_SHIFT) + 10) / 11),
		RECIP_W'(((1 << RECIP_SHIFT) + 11) / 12),
		RECIP_W'(((1 << RECIP_SHIFT) + 12) / 13),
		RECIP_W'(((1 << RECIP_SHIFT) + 13) / 14),
		RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15)
	};

	typedef struct packed {
		logic mode;
		logic [STORE_AW-1:0] texel_index;
		logic [31:0] texel_argb;
		logic [COORD_W-1:0] pixel_col;
		logic [COORD_W-1:0] pixel_row;
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic [7:0] byte_third;
	} scao_in_t;

	typedef struct packed {
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [7:0] out_third;
		logic covered;
	} scao_out_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} scao_adv_t;

endpackage
`default_nettype wire

// File: hdl/scao_mix.sv
`default_nettype none
module scao_mix
	import scao_pkg::*;
(
	input wire logic clk,
	input wire scao_adv_t adv,
	input wire logic [7:0] src,
	input wire logic [7:0] dst,
	input wire logic [7:0] alpha,
	output logic [7:0] mixed
);

	logic [SUM_W-1:0] sum_s3;
	logic [SUM_W:0] rounded;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= SUM_W'(src) * SUM_W'(alpha) + SUM_W'(dst) * SUM_W'(FULL_ALPHA - alpha);
		end
	end

	// Exact division by 255 for sums of two 8-by-8 products up to 255 * 255.
	assign rounded = {1'b0, sum_s3} + (SUM_W + 1)'(1) + (SUM_W + 1)'(sum_s3[SUM_W-1:8]);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			mixed <= rounded[15:8];
		end
	end

endmodule
`default_nettype wire

// File: hdl/scaled_cursor_alpha_overlay_core.sv
`default_nettype none
// Cursor overlay: load items write ARGB texels into a 4096-word single-port store, and pixel
// items inside the magnified cursor rectangle are alpha blended with the texel under them,
// all others pass through with covered low. The block takes one item per clock while results
// are accepted; load items give no result. Each item makes exactly one store access as it
// leaves the first stage, so a texel loaded by an earlier item is always seen by later
// pixels. The user writes configuration only while the block is idle; nothing enforces it.
module scaled_cursor_alpha_overlay_core
	import scao_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire scao_in_t item,
	output logic result_valid,
	input wire logic result_ready,
	output scao_out_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [ORIGIN_W-1:0] origin_x_q;
	logic [ORIGIN_W-1:0] origin_y_q;
	logic [SCALE_W-1:0] magnify_q;
	logic [IMAGE_W-1:0] image_width_q;
	logic [IMAGE_W-1:0] image_height_q;
	logic [1:0] color_order_q;

	logic [SCALE_W-1:0] scale;
	logic [IMAGE_W-1:0] iw;
	logic [IMAGE_W-1:0] ih;
	logic [SPAN_W-1:0] span_x;
	logic [SPAN_W-1:0] span_y;
	logic [DELTA_W-1:0] dx;
	logic [DELTA_W-1:0] dy;
	logic inside_x;
	logic inside_y;
	logic hit;
	logic [31:0] prod_x;
	logic [31:0] prod_y;

	logic en1;
	logic en2;
	logic en3;
	logic en4;
	scao_adv_t adv;

	logic valid_s1;
	logic mode_s1;
	logic hit_s1;
	logic [STORE_AW-1:0] index_s1;
	logic [31:0] argb_s1;
	logic [IMAGE_W-1:0] tx_s1;
	logic [IMAGE_W-1:0] ty_s1;
	logic [7:0] b0_s1;
	logic [7:0] b1_s1;
	logic [7:0] b2_s1;

	logic [ADDR_SUM_W-1:0] addr_sum;
	logic [STORE_AW-1:0] store_addr;
	logic store_rd;
	logic store_wr;
	logic [31:0] cursor_store_q [STORE_DEPTH];

	logic valid_s2;
	logic hit_s2;
	logic [31:0] texel_s2;
	logic [7:0] b0_s2;
	logic [7:0] b1_s2;
	logic [7:0] b2_s2;

	logic [31:0] texel;
	logic [7:0] alpha;
	logic [7:0] src0;
	logic [7:0] src2;

	logic valid_s3;
	logic hit_s3;
	logic valid_s4;
	logic hit_s4;
	logic [7:0] mixed0;
	logic [7:0] mixed1;
	logic [7:0] mixed2;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			magnify_q <= '0;
			image_width_q <= '0;
			image_height_q <= '0;
			color_order_q <= ORDER_RGB;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_ORIGIN_X: origin_x_q <= pwdata[ORIGIN_W-1:0];
				REG_ORIGIN_Y: origin_y_q <= pwdata[ORIGIN_W-1:0];
				REG_MAGNIFY: magnify_q <= pwdata[SCALE_W-1:0];
				REG_IMAGE_WIDTH: image_width_q <= pwdata[IMAGE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[IMAGE_W-1:0];
				REG_COLOR_ORDER: color_order_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ORIGIN_X: prdata = {{(32 - ORIGIN_W){origin_x_q[ORIGIN_W-1]}}, origin_x_q};
			REG_ORIGIN_Y: prdata = {{(32 - ORIGIN_W){origin_y_q[ORIGIN_W-1]}}, origin_y_q};
			REG_MAGNIFY: prdata = 32'(magnify_q);
			REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			REG_COLOR_ORDER: prdata = 32'(color_order_q);
			default: prdata = '0;
		endcase
	end

	// Stage enables: a stage loads when it is empty or its content moves on.
	assign en4 = !valid_s4 || result_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_ready = en1;
	assign adv.s3 = en3;
	assign adv.s4 = en4;

	// Entry: rectangle test and texel coordinates by reciprocal multiplication.
	assign scale = (int'(magnify_q) > MAX_MAGNIFY) ? SCALE_W'(MAX_MAGNIFY) : magnify_q;
	assign iw = (int'(image_width_q) > MAX_IMAGE_SIDE) ? IMAGE_W'(MAX_IMAGE_SIDE) : image_width_q;
	assign ih = (int'(image_height_q) > MAX_IMAGE_SIDE) ? IMAGE_W'(MAX_IMAGE_SIDE) : image_height_q;
	assign span_x = SPAN_W'(iw) * SPAN_W'(scale);
	assign span_y = SPAN_W'(ih) * SPAN_W'(scale);

	assign dx = {2'b00, item.pixel_col} - {origin_x_q[ORIGIN_W-1], origin_x_q};
	assign dy = {2'b00, item.pixel_row} - {origin_y_q[ORIGIN_W-1], origin_y_q};
	assign inside_x = !dx[DELTA_W-1] && (dx[DELTA_W-2:0] < (DELTA_W - 1)'(span_x));
	assign inside_y = !dy[DELTA_W-1] && (dy[DELTA_W-2:0] < (DELTA_W - 1)'(span_y));

	assign hit = (scale != '0)
		&& (color_order_q == ORDER_RGB || color_order_q == ORDER_BGR)
		&& (int'(item.pixel_col) < FRAME_SIDE) && (int'(item.pixel_row) < FRAME_SIDE)
		&& inside_x && inside_y;

	assign prod_x = 32'(dx[DELTA_W-2:0]) * 32'(RECIP_LUT[scale]);
	assign prod_y = 32'(dy[DELTA_W-2:0]) * 32'(RECIP_LUT[scale]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= item.mode;
			hit_s1 <= hit;
			index_s1 <= item.texel_index;
			argb_s1 <= item.texel_argb;
			tx_s1 <= prod_x[RECIP_SHIFT +: IMAGE_W];
			ty_s1 <= prod_y[RECIP_SHIFT +: IMAGE_W];
			b0_s1 <= item.byte_first;
			b1_s1 <= item.byte_second;
			b2_s1 <= item.byte_third;
		end
	end

	// Cursor store: one access per item, write for a load and read for a pixel.
	assign addr_sum = ADDR_SUM_W'(ty_s1) * ADDR_SUM_W'(iw) + ADDR_SUM_W'(tx_s1);
	assign store_addr = (mode_s1 == MODE_PIXEL) ? addr_sum[STORE_AW-1:0] : index_s1;
	assign store_rd = en2 && valid_s1 && (mode_s1 == MODE_PIXEL);
	assign store_wr = en2 && valid_s1 && (mode_s1 == MODE_LOAD);

	always_ff @(posedge clk) begin
		if (store_wr) begin
			cursor_store_q[store_addr] <= argb_s1;
		end
		if (store_rd) begin
			texel_s2 <= cursor_store_q[store_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && (mode_s1 == MODE_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			hit_s2 <= hit_s1;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			b2_s2 <= b2_s1;
		end
	end

	// A pixel outside the cursor blends a zero texel, which returns the frame byte unchanged.
	assign texel = hit_s2 ? texel_s2 : 32'h0000_0000;
	assign alpha = texel[31:24];
	assign src0 = (color_order_q == ORDER_BGR) ? texel[7:0] : texel[23:16];
	assign src2 = (color_order_q == ORDER_BGR) ? texel[23:16] : texel[7:0];

	scao_mix u_mix0 (
		.clk(clk),
		.adv(adv),
		.src(src0),
		.dst(b0_s2),
		.alpha(alpha),
		.mixed(mixed0)
	);

	scao_mix u_mix1 (
		.clk(clk),
		.adv(adv),
		.src(texel[15:8]),
		.dst(b1_s2),
		.alpha(alpha),
		.mixed(mixed1)
	);

	scao_mix u_mix2 (
		.clk(clk),
		.adv(adv),
		.src(src2),
		.dst(b2_s2),
		.alpha(alpha),
		.mixed(mixed2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hit_s3 <= hit_s2;
		end
		if (en4) begin
			hit_s4 <= hit_s3;
		end
	end

	assign result_valid = valid_s4;
	assign result.out_first = mixed0;
	assign result.out_second = mixed1;
	assign result.out_third = mixed2;
	assign result.covered = hit_s4;

	a_texel_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en3) |=> $stable(texel_s2))
		else $error("Store read data changed while its pixel was stalled.");

	a_pixel_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && mode_s1 == MODE_PIXEL) |=> valid_s2)
		else $error("A pixel transfer was lost after the store read.");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && mode_s1 == MODE_LOAD) |=> !valid_s2)
		else $error("A texel load produced a result.");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(store_rd && store_wr))
		else $error("Store read and write in the same cycle.");

endmodule
`default_nettype wire

// File: tb/sv/scao_overlay_checker.sv
module scao_overlay_checker
	import scao_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input scao_in_t item,
	input logic result_valid,
	input logic result_ready,
	input scao_out_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output int outstanding,
	output int errors
);

	logic [31:0] texels [STORE_DEPTH];
	logic signed [ORIGIN_W-1:0] org_x, org_y;
	logic [SCALE_W-1:0] mag;
	logic [IMAGE_W-1:0] img_w, img_h;
	logic [1:0] color_sel;

	scao_out_t blended_queue [$];
	scao_out_t head;
	bit match;

	function automatic logic [7:0] alpha_mix(int src, int dst, int alpha);
		return 8'((src * alpha + dst * (int'(FULL_ALPHA) - alpha)) / int'(FULL_ALPHA));
	endfunction

	function automatic scao_out_t blend_pixel(scao_in_t px);
		scao_out_t res;
		int scale, iw, ih, dx, dy;
		logic [31:0] t;
		res.out_first = px.byte_first;
		res.out_second = px.byte_second;
		res.out_third = px.byte_third;
		res.covered = 1'b0;
		scale = int'(mag);
		if (scale > MAX_MAGNIFY) scale = MAX_MAGNIFY;
		iw = int'(img_w);
		if (iw > MAX_IMAGE_SIDE) iw = MAX_IMAGE_SIDE;
		ih = int'(img_h);
		if (ih > MAX_IMAGE_SIDE) ih = MAX_IMAGE_SIDE;
		dx = int'(px.pixel_col) - int'(org_x);
		dy = int'(px.pixel_row) - int'(org_y);
		if (scale != 0 && (color_sel == ORDER_RGB || color_sel == ORDER_BGR) &&
				int'(px.pixel_col) < FRAME_SIDE && int'(px.pixel_row) < FRAME_SIDE &&
				dx >= 0 && dy >= 0 && dx < iw * scale && dy < ih * scale) begin
			t = texels[((dy / scale) * iw + dx / scale) % STORE_DEPTH];
			res.out_second = alpha_mix(t[15:8], px.byte_second, t[31:24]);
			if (color_sel == ORDER_RGB) begin
				res.out_first = alpha_mix(t[23:16], px.byte_first, t[31:24]);
				res.out_third = alpha_mix(t[7:0], px.byte_third, t[31:24]);
			end else begin
				res.out_first = alpha_mix(t[7:0], px.byte_first, t[31:24]);
				res.out_third = alpha_mix(t[23:16], px.byte_third, t[31:24]);
			end
			res.covered = 1'b1;
		end
		return res;
	endfunction

	function automatic bit field_ok(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blended_queue.delete();
			outstanding <= 0;
			errors = 0;
			org_x = '0;
			org_y = '0;
			mag = '0;
			img_w = '0;
			img_h = '0;
			color_sel = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ORIGIN_X: org_x = pwdata[ORIGIN_W-1:0];
					REG_ORIGIN_Y: org_y = pwdata[ORIGIN_W-1:0];
					REG_MAGNIFY: mag = pwdata[SCALE_W-1:0];
					REG_IMAGE_WIDTH: img_w = pwdata[IMAGE_W-1:0];
					REG_IMAGE_HEIGHT: img_h = pwdata[IMAGE_W-1:0];
					REG_COLOR_ORDER: color_sel = pwdata[1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (blended_queue.size() == 0) begin
					$display("%0t: result %h with no pixel pending", $time, result);
					errors++;
				end else begin
					head = blended_queue.pop_front();
					match = field_ok("out_first", head.out_first, result.out_first) &
						field_ok("out_second", head.out_second, result.out_second) &
						field_ok("out_third", head.out_third, result.out_third) &
						field_ok("covered", head.covered, result.covered);
					if (!match) errors++;
				end
			end
			if (item_valid && item_ready) begin
				if (item.mode == MODE_LOAD) begin
					texels[item.texel_index] = item.texel_argb;
				end else begin
					blended_queue.push_back(blend_pixel(item));
				end
			end
			outstanding <= blended_queue.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
module tb;
	import scao_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid, item_ready;
	scao_in_t item;
	logic result_valid, result_ready;
	scao_out_t result;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	int pending_pixels, fail_count;
	int items_sent = 0;
	bit quiet_tx = 1'b0, quiet_rx = 1'b0, hold_results = 1'b0, random_reloads = 1'b0;
	bit texel_loaded [STORE_DEPTH];
	int cfg_org_x, cfg_org_y, cfg_order, eff_scale, eff_w, eff_h;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	scaled_cursor_alpha_overlay_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	scao_overlay_checker overlay_watch (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.outstanding(pending_pixels),
		.errors(fail_count)
	);

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic logic [7:0] channel_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic scao_in_t random_item();
		scao_in_t p;
		p.mode = 1'($urandom_range(0, 1));
		p.texel_index = STORE_AW'($urandom_range(0, STORE_DEPTH - 1));
		p.texel_argb = $urandom;
		p.pixel_col = COORD_W'($urandom_range(0, FRAME_SIDE - 1));
		p.pixel_row = COORD_W'($urandom_range(0, FRAME_SIDE - 1));
		p.byte_first = channel_byte();
		p.byte_second = channel_byte();
		p.byte_third = channel_byte();
		return p;
	endfunction

	function automatic int pick_side();
		case ($urandom_range(0, 19))
			0: return 0;
			1, 2: return $urandom_range(65, 127);
			3, 4, 5: return $urandom_range(9, 64);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int pick_origin();
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 8191)) - 4096;
			1: return $urandom_range(0, 1) ? -4096 + int'($urandom_range(0, 63))
				: 4095 - int'($urandom_range(0, 63));
			default: return int'($urandom_range(0, 300)) - 50;
		endcase
	endfunction

	task automatic transfer_item(input scao_in_t p);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= p;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && item_ready));
		items_sent++;
	endtask

	task automatic send_load(input int idx, input logic [31:0] argb);
		scao_in_t p;
		p = random_item();
		p.mode = MODE_LOAD;
		p.texel_index = STORE_AW'(idx);
		p.texel_argb = argb;
		texel_loaded[idx] = 1'b1;
		transfer_item(p);
	endtask

	// A covered pixel must never read a texel that was never loaded, so one is loaded first.
	task automatic send_pixel(input int col, input int row,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		scao_in_t p;
		int dx, dy, idx;
		dx = col - cfg_org_x;
		dy = row - cfg_org_y;
		if (eff_scale != 0 && (cfg_order == ORDER_RGB || cfg_order == ORDER_BGR) &&
				dx >= 0 && dy >= 0 && dx < eff_w * eff_scale && dy < eff_h * eff_scale) begin
			idx = (dy / eff_scale) * eff_w + dx / eff_scale;
			if (!texel_loaded[idx] || (random_reloads && $urandom_range(0, 3) == 0))
				send_load(idx, $urandom);
		end
		p = random_item();
		p.mode = MODE_PIXEL;
		p.pixel_col = COORD_W'(col);
		p.pixel_row = COORD_W'(row);
		p.byte_first = b0;
		p.byte_second = b1;
		p.byte_third = b2;
		transfer_item(p);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] which, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int ox, input int oy, input int mag,
			input int w, input int h, input int order);
		settle();
		cfg_org_x = ox;
		cfg_org_y = oy;
		cfg_order = order;
		eff_scale = (mag > MAX_MAGNIFY) ? MAX_MAGNIFY : mag;
		eff_w = (w > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : w;
		eff_h = (h > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : h;
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_MAGNIFY, mag);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_COLOR_ORDER, order);
	endtask

	initial begin
		int stall;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				result_ready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_results = 1'b0;
			end
			stall = quiet_rx ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	initial begin
		int n, mag, order, phase, col, row, span_x, span_y;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(10, 20, 2, 4, 3, ORDER_RGB);
		send_load(0, 32'h00_12_34_56);
		send_load(1, 32'hff_ab_cd_ef);
		send_load(2, 32'h80_ff_00_7f);
		send_load(11, 32'h7f_00_ff_80);
		send_pixel(10, 20, 8'h00, 8'h00, 8'h00);
		send_pixel(11, 21, 8'hff, 8'hff, 8'hff);
		send_pixel(12, 20, 8'h00, 8'h80, 8'hff);
		send_pixel(14, 20, 8'hff, 8'h00, 8'h00);
		send_pixel(17, 25, 8'hc8, 8'h64, 8'h32);
		send_pixel(18, 25, 8'h11, 8'h22, 8'h33);
		send_pixel(9, 20, 8'h44, 8'h55, 8'h66);
		send_pixel(17, 26, 8'h77, 8'h88, 8'h99);
		send_pixel(10, 19, 8'haa, 8'hbb, 8'hcc);
		send_pixel(4095, 4095, 8'hff, 8'hff, 8'hff);
		configure(10, 20, 2, 4, 3, ORDER_BGR);
		send_pixel(14, 20, 8'h00, 8'hff, 8'h00);
		send_pixel(17, 25, 8'hc8, 8'h64, 8'h32);
		configure(10, 20, 2, 4, 3, 2);
		send_pixel(10, 20, 8'h01, 8'h02, 8'h03);
		configure(10, 20, 2, 4, 3, 3);
		send_pixel(12, 20, 8'h04, 8'h05, 8'h06);
		configure(10, 20, 0, 4, 3, ORDER_RGB);
		send_pixel(10, 20, 8'h07, 8'h08, 8'h09);
		configure(10, 20, 15, 4, 3, ORDER_RGB);
		send_pixel(41, 43, 8'h10, 8'h20, 8'h30);
		send_pixel(42, 20, 8'h40, 8'h50, 8'h60);
		configure(0, 0, 1, 127, 127, ORDER_RGB);
		send_pixel(63, 63, 8'hff, 8'h00, 8'hff);
		send_pixel(64, 0, 8'h00, 8'hff, 8'h00);
		configure(0, 0, 1, 0, 3, ORDER_RGB);
		send_pixel(0, 0, 8'h12, 8'h34, 8'h56);
		configure(-4096, -4096, 8, 64, 64, ORDER_RGB);
		send_pixel(0, 0, 8'h65, 8'h43, 8'h21);
		configure(4095, 4095, 1, 1, 1, ORDER_BGR);
		send_pixel(4095, 4095, 8'h00, 8'h00, 8'h00);

		random_reloads = 1'b1;
		phase = 0;
		while (items_sent < 530) begin
			case ($urandom_range(0, 9))
				0: mag = 0;
				1: mag = $urandom_range(9, 15);
				default: mag = $urandom_range(1, 8);
			endcase
			order = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
			configure(pick_origin(), pick_origin(), mag, pick_side(), pick_side(), order);
			quiet_tx = ($urandom_range(0, 3) == 0);
			quiet_rx = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 40);
			if (phase == 0) begin
				// Results are held off while pixels keep coming, so the pipeline backs up.
				quiet_tx = 1'b1;
				hold_results = 1'b1;
				n = 60;
			end
			span_x = eff_w * ((eff_scale == 0) ? 1 : eff_scale);
			span_y = eff_h * ((eff_scale == 0) ? 1 : eff_scale);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					send_load($urandom_range(0, STORE_DEPTH - 1), $urandom);
				end else if ($urandom_range(0, 9) < 7) begin
					col = cfg_org_x - 2 + int'($urandom_range(0, span_x + 4));
					row = cfg_org_y - 2 + int'($urandom_range(0, span_y + 4));
					if (col < 0 || col >= FRAME_SIDE) col = $urandom_range(0, FRAME_SIDE - 1);
					if (row < 0 || row >= FRAME_SIDE) row = $urandom_range(0, FRAME_SIDE - 1);
					send_pixel(col, row, channel_byte(), channel_byte(), channel_byte());
				end else begin
					send_pixel($urandom_range(0, FRAME_SIDE - 1), $urandom_range(0, FRAME_SIDE - 1),
						channel_byte(), channel_byte(), channel_byte());
				end
			end
			phase++;
		end

		settle();
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/scao_pkg.sv
hdl/scao_mix.sv
hdl/scaled_cursor_alpha_overlay_core.sv
tb/sv/scao_overlay_checker.sv
tb/sv/tb.sv
